### design/assert_macros.svh
// Assertion macros used by the port-level checker of the clipper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled during reset.
`define HPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define HPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  `HPC_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

### design/hpc_pkg.sv
// Types and constants of the half-plane polygon clipper.
`default_nettype none

package hpc_pkg;

  localparam int COORD_W    = 32;  // Q16.16 coordinates and coefficients
  localparam int COORD_FRAC = 16;  // fraction bits of Q16.16
  localparam int SIDE_W     = 64;  // saturated Q32.32 side value
  localparam int ACC_W      = 65;  // exact side sum before saturation
  localparam int MUL_W      = 33;  // operand width of the shared multiplier
  localparam int PROD_W     = 2 * MUL_W;

  // Result item kinds
  typedef enum logic [1:0] {
    KIND_KEPT  = 2'd0,
    KIND_CROSS = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LINE_A = 2'd0,
    REG_LINE_B = 2'd1,
    REG_LINE_C = 2'd2,
    REG_MARGIN = 2'd3
  } cfg_reg_t;

  // Sequencer states, one-hot
  typedef enum logic [15:0] {
    S_IDLE        = 16'h0001,
    S_MUL_A       = 16'h0002,
    S_MUL_B       = 16'h0004,
    S_ACC         = 16'h0008,
    S_SAT         = 16'h0010,
    S_CLOSE_SETUP = 16'h0020,
    S_EDGE        = 16'h0040,
    S_DIV_INIT    = 16'h0080,
    S_DIV         = 16'h0100,
    S_MUL_X       = 16'h0200,
    S_MUL_Y       = 16'h0400,
    S_FIX_Y       = 16'h0800,
    S_EMIT_CROSS  = 16'h1000,
    S_EMIT_KEPT   = 16'h2000,
    S_DONE_EDGE   = 16'h4000,
    S_EMIT_END    = 16'h8000
  } state_t;

endpackage

`default_nettype wire

### design/hpc_if.sv
// Valid/ready channel interfaces of the clipper: vertices, results, configuration.
`default_nettype none

interface hpc_vertex_if import hpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      final_vertex;

  modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

interface hpc_result_if import hpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  kind_t                     item_kind;

  modport source (output valid, out_x, out_y, item_kind, input ready);
  modport sink   (input valid, out_x, out_y, item_kind, output ready);
endinterface

interface hpc_cfg_if import hpc_pkg::*; ();
  logic               valid;
  logic               ready;
  cfg_reg_t           index;
  logic [COORD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/halfplane_polygon_clipper.sv
// Half-plane polygon clipper: one Sutherland-Hodgman pass over a streamed polygon.
//
// Channels: vtx takes one polygon vertex per transfer (final_vertex marks the last one);
// res gives kept vertices, crossing points and one end marker per polygon; the user writes
// line_a, line_b, line_c and margin on cfg only while no vertex is in work (the sequencer
// is idle), which the block does not enforce. A vertex is inside when line_a*x +
// line_b*y + line_c - margin >= 0 (Q32.32, saturated).
// One vertex at a time passes through a small sequencer around one 33x33 multiplier.
// The side value is formed in steps (two products, accumulate, saturate). Each edge then
// either has nothing to emit, emits a kept vertex, or finds a crossing with the restoring
// divider that retires one quotient bit per cycle, emits it, and also emits the end vertex
// when it is kept. A final vertex adds a setup state, the closing edge and the end marker.
// vtx.ready is high only between vertices.
//
// Reset: clears the line registers to zero, drops any partial polygon and the result
// register. When res stalls, the sequencer holds on the pending result until the
// output register frees up; the result register is a separate stage, so the last
// result of a vertex may still wait while the next vertex is accepted.
`default_nettype none

module halfplane_polygon_clipper import hpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  hpc_vertex_if.sink   vtx,
  hpc_result_if.source res,
  hpc_cfg_if.sink      cfg
);

  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS);
  localparam logic [CW-1:0] LastStep = CW'(FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] RoundBias = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

  state_t state;
  state_t state_next;

  // configuration
  logic signed [COORD_W-1:0] line_a;
  logic signed [COORD_W-1:0] line_b;
  logic signed [COORD_W-1:0] line_c;
  logic signed [COORD_W-1:0] margin;

  // current vertex
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic                      cur_last;
  logic signed [SIDE_W-1:0]  cur_side;

  // polygon state
  logic                      have_first;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_y;
  logic signed [SIDE_W-1:0]  first_side;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;
  logic signed [SIDE_W-1:0]  prev_side;

  // edge under work
  logic                      edge_close;
  logic signed [COORD_W-1:0] sx;
  logic signed [COORD_W-1:0] sy;
  logic signed [SIDE_W-1:0]  ss;
  logic signed [COORD_W-1:0] ex;
  logic signed [COORD_W-1:0] ey;
  logic signed [SIDE_W-1:0]  es;

  // arithmetic
  logic signed [ACC_W-1:0]   acc;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [SIDE_W-1:0]         rem;
  logic [SIDE_W-1:0]         den;
  logic [QW-1:0]             quo;
  logic [CW-1:0]             step;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;

  // output register
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  kind_t                     out_kind;

  logic                      in_xfer;
  logic                      out_free;
  logic                      emit_now;
  logic signed [COORD_W-1:0] emit_x;
  logic signed [COORD_W-1:0] emit_y;
  kind_t                     emit_kind;

  logic signed [SIDE_W-1:0]  side_sat;
  logic [SIDE_W-1:0]         mag_s;
  logic [SIDE_W-1:0]         mag_e;
  logic [SIDE_W-1:0]         den_sum;
  logic [SIDE_W:0]           rem_sh;
  logic                      div_ge;
  logic signed [PROD_W-1:0]  prod_adj;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [COORD_W-1:0] lerp_base;
  logic signed [COORD_W-1:0] lerp_val;

  assign in_xfer   = vtx.valid && vtx.ready;
  assign vtx.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid     = out_valid;
  assign res.out_x     = out_x;
  assign res.out_y     = out_y;
  assign res.item_kind = out_kind;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_a <= '0;
      line_b <= '0;
      line_c <= '0;
      margin <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_LINE_A: line_a <= cfg.data;
        REG_LINE_B: line_b <= cfg.data;
        REG_LINE_C: line_c <= cfg.data;
        REG_MARGIN: margin <= cfg.data;
        default: ;
      endcase
    end
  end

  // Saturate the exact side sum to Q32.32
  always_comb begin
    if (acc[ACC_W-1] == acc[ACC_W-2]) begin
      side_sat = acc[SIDE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      side_sat = {1'b1, {(SIDE_W-1){1'b0}}};
    end else begin
      side_sat = {1'b0, {(SIDE_W-1){1'b1}}};
    end
  end

  // Divider operands and one restoring step
  assign mag_s   = ss[SIDE_W-1] ? SIDE_W'(-ss) : SIDE_W'(ss);
  assign mag_e   = es[SIDE_W-1] ? SIDE_W'(-es) : SIDE_W'(es);
  assign den_sum = mag_s + mag_e;
  assign rem_sh  = {rem, 1'b0};
  assign div_ge  = (rem_sh >= {1'b0, den});

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_A: begin
        mul_a = MUL_W'(line_a);
        mul_b = MUL_W'(cur_x);
      end
      S_MUL_B: begin
        mul_a = MUL_W'(line_b);
        mul_b = MUL_W'(cur_y);
      end
      S_MUL_X: begin
        mul_a = signed'(MUL_W'(quo));
        mul_b = MUL_W'(ex) - MUL_W'(sx);
      end
      S_MUL_Y: begin
        mul_a = signed'(MUL_W'(quo));
        mul_b = MUL_W'(ey) - MUL_W'(sy);
      end
      default: ;
    endcase
  end

  // Scale the product back, truncating toward zero, and add the start coordinate
  assign prod_adj  = prod + (prod[PROD_W-1] ? RoundBias : '0);
  assign prod_q    = prod_adj >>> FRAC_BITS;
  assign lerp_base = (state == S_FIX_Y) ? sy : sx;
  assign lerp_val  = lerp_base + prod_q[COORD_W-1:0];

  // Result select
  assign out_free = !out_valid || res.ready;
  always_comb begin
    emit_now  = 1'b0;
    emit_x    = '0;
    emit_y    = '0;
    emit_kind = KIND_END;
    case (state)
      S_EMIT_CROSS: begin
        emit_now  = out_free;
        emit_x    = px;
        emit_y    = py;
        emit_kind = KIND_CROSS;
      end
      S_EMIT_KEPT: begin
        emit_now  = out_free;
        emit_x    = ex;
        emit_y    = ey;
        emit_kind = KIND_KEPT;
      end
      S_EMIT_END: begin
        emit_now = out_free;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:        if (in_xfer) state_next = S_MUL_A;
      S_MUL_A:       state_next = S_MUL_B;
      S_MUL_B:       state_next = S_ACC;
      S_ACC:         state_next = S_SAT;
      S_SAT: begin
        if (have_first) begin
          state_next = S_EDGE;
        end else if (cur_last) begin
          state_next = S_CLOSE_SETUP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE_SETUP: state_next = S_EDGE;
      S_EDGE: begin
        if (!es[SIDE_W-1]) begin
          state_next = ss[SIDE_W-1] ? S_DIV_INIT : S_EMIT_KEPT;
        end else begin
          state_next = ss[SIDE_W-1] ? S_DONE_EDGE : S_DIV_INIT;
        end
      end
      S_DIV_INIT:    state_next = (den_sum == '0) ? S_EMIT_CROSS : S_DIV;
      S_DIV:         if (step == LastStep) state_next = S_MUL_X;
      S_MUL_X:       state_next = S_MUL_Y;
      S_MUL_Y:       state_next = S_FIX_Y;
      S_FIX_Y:       state_next = S_EMIT_CROSS;
      S_EMIT_CROSS: begin
        if (out_free) state_next = es[SIDE_W-1] ? S_DONE_EDGE : S_EMIT_KEPT;
      end
      S_EMIT_KEPT:   if (out_free) state_next = S_DONE_EDGE;
      S_DONE_EDGE: begin
        if (edge_close) begin
          state_next = S_EMIT_END;
        end else if (cur_last) begin
          state_next = S_CLOSE_SETUP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_END:    if (out_free) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      have_first <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SAT) begin
        have_first <= 1'b1;
      end else if (state == S_EMIT_END && out_free) begin
        have_first <= 1'b0;
      end
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_x    <= emit_x;
      out_y    <= emit_y;
      out_kind <= emit_kind;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cur_x    <= vtx.vertex_x;
          cur_y    <= vtx.vertex_y;
          cur_last <= vtx.final_vertex;
          acc      <= (ACC_W'(line_c) - ACC_W'(margin)) <<< COORD_FRAC;
        end
      end
      S_MUL_A: begin
        prod <= mul_a * mul_b;
      end
      S_MUL_B: begin
        prod <= mul_a * mul_b;
        acc  <= acc + ACC_W'(prod);
      end
      S_ACC: begin
        acc <= acc + ACC_W'(prod);
      end
      S_SAT: begin
        // open the edge from the previous vertex, then advance the previous vertex
        cur_side   <= side_sat;
        sx         <= prev_x;
        sy         <= prev_y;
        ss         <= prev_side;
        ex         <= cur_x;
        ey         <= cur_y;
        es         <= side_sat;
        edge_close <= 1'b0;
        prev_x     <= cur_x;
        prev_y     <= cur_y;
        prev_side  <= side_sat;
        if (!have_first) begin
          first_x    <= cur_x;
          first_y    <= cur_y;
          first_side <= side_sat;
        end
      end
      S_CLOSE_SETUP: begin
        sx         <= cur_x;
        sy         <= cur_y;
        ss         <= cur_side;
        ex         <= first_x;
        ey         <= first_y;
        es         <= first_side;
        edge_close <= 1'b1;
      end
      S_DIV_INIT: begin
        den  <= den_sum;
        step <= '0;
        if (den_sum == '0) begin
          px <= sx;
          py <= sy;
        end else if (mag_s >= den_sum) begin
          quo <= QW'(1);
          rem <= mag_s - den_sum;
        end else begin
          quo <= '0;
          rem <= mag_s;
        end
      end
      S_DIV: begin
        step <= step + CW'(1);
        quo  <= {quo[QW-2:0], div_ge};
        rem  <= div_ge ? SIDE_W'(rem_sh - {1'b0, den}) : rem_sh[SIDE_W-1:0];
      end
      S_MUL_X: begin
        prod <= mul_a * mul_b;
      end
      S_MUL_Y: begin
        prod <= mul_a * mul_b;
        px   <= lerp_val;
      end
      S_FIX_Y: begin
        py <= lerp_val;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### design/hpc_checker.sv
// Port-level checker of the clipper and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module hpc_checker import hpc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_x,
  input logic signed [COORD_W-1:0] out_y,
  input kind_t                     out_kind
);

  // the block works on one vertex at a time
  `HPC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "vertex accepted while busy")

  // a stalled result holds its payload
  `HPC_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_kind), "stalled result changed")

  // no result of a new vertex appears right after its transfer; the side value comes first
  `HPC_ASSERT_NEXT(a_no_early_result, clk, rst, in_valid && in_ready && !out_valid, !out_valid, "result appeared right after vertex transfer")

endmodule

bind halfplane_polygon_clipper hpc_checker u_hpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (vtx.valid),
  .in_ready  (vtx.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_x     (res.out_x),
  .out_y     (res.out_y),
  .out_kind  (res.item_kind)
);

`default_nettype wire

### tb/halfplane_clip_checker.sv
// Checker for the half-plane polygon clipper: predicts clipped vertices and compares results.
`timescale 1ns / 1ps

module halfplane_clip_checker import hpc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  hpc_vertex_if vtx,
  hpc_result_if res,
  hpc_cfg_if    cfg,
  output int    errors,
  output int    pending,
  output int    checked,
  output int    crossings
);

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    kind_t                     kind;
  } clip_point_t;

  // Points still owed by the block, oldest first
  clip_point_t expected_points[$];
  clip_point_t want;

  // Line registers as the block should hold them
  logic signed [COORD_W-1:0] coef_a, coef_b, coef_c, eps;

  // Open polygon: its first vertex and the vertex before the current one
  logic signed [COORD_W-1:0] start_x, start_y, last_x, last_y;
  logic signed [SIDE_W-1:0]  start_side, last_side;
  logic                      open_polygon;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] clip check: %s", $time, what);
  endtask

  // Append one owed point behind the others
  task automatic owe_point(input clip_point_t p);
    expected_points.insert(expected_points.size(), p);
  endtask

  // Queue the crossing point of edge s->e; t is the truncated fraction of the way along
  task automatic cross_point(input logic signed [COORD_W-1:0] sx, sy,
                             input logic signed [SIDE_W-1:0] ss,
                             input logic signed [COORD_W-1:0] ex, ey,
                             input logic signed [SIDE_W-1:0] es);
    logic [SIDE_W-1:0] num, den;
    logic [127:0]      frac;
    longint            t, px, py;
    num = ss[SIDE_W-1] ? ~ss + 64'd1 : ss;
    den = num + (es[SIDE_W-1] ? ~es + 64'd1 : es);
    if (den == 0) begin
      owe_point('{sx, sy, KIND_CROSS});
    end else begin
      frac = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
      t = longint'(frac[63:0]);
      px = longint'(sx) + t * (longint'(ex) - longint'(sx)) / (longint'(1) <<< FRAC_BITS);
      py = longint'(sy) + t * (longint'(ey) - longint'(sy)) / (longint'(1) <<< FRAC_BITS);
      owe_point('{32'(px), 32'(py), KIND_CROSS});
    end
  endtask

  // One clipping step over edge s->e
  task automatic edge_pass(input logic signed [COORD_W-1:0] sx, sy,
                           input logic signed [SIDE_W-1:0] ss,
                           input logic signed [COORD_W-1:0] ex, ey,
                           input logic signed [SIDE_W-1:0] es);
    if (!es[SIDE_W-1]) begin
      if (ss[SIDE_W-1]) cross_point(sx, sy, ss, ex, ey, es);
      owe_point('{ex, ey, KIND_KEPT});
    end else if (!ss[SIDE_W-1]) begin
      cross_point(sx, sy, ss, ex, ey, es);
    end
  endtask

  // Side value of a vertex, then the edge into it and, on the last one, the closing edge
  task automatic accept_vertex(input logic signed [COORD_W-1:0] x, y, input logic last);
    logic signed [95:0]       wa, wb, wc, wm, wx, wy, acc;
    logic signed [SIDE_W-1:0] s;
    wa = coef_a;
    wb = coef_b;
    wc = coef_c;
    wm = eps;
    wx = x;
    wy = y;
    acc = wa * wx + wb * wy + (wc <<< COORD_FRAC) - (wm <<< COORD_FRAC);
    // saturate to the signed 64-bit range
    if (acc[95:63] != {33{acc[95]}}) s = acc[95] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else s = acc[63:0];
    if (!open_polygon) begin
      start_x = x;
      start_y = y;
      start_side = s;
      open_polygon = 1'b1;
    end else begin
      edge_pass(last_x, last_y, last_side, x, y, s);
    end
    last_x = x;
    last_y = y;
    last_side = s;
    if (last) begin
      edge_pass(x, y, s, start_x, start_y, start_side);
      owe_point('{'0, '0, KIND_END});
      open_polygon = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      coef_a = '0;
      coef_b = '0;
      coef_c = '0;
      eps = '0;
      start_x = '0;
      start_y = '0;
      start_side = '0;
      last_x = '0;
      last_y = '0;
      last_side = '0;
      open_polygon = 1'b0;
      expected_points.delete();
      errors = 0;
      checked = 0;
      crossings = 0;
    end else begin
      // apply register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LINE_A: coef_a = cfg.data;
          REG_LINE_B: coef_b = cfg.data;
          REG_LINE_C: coef_c = cfg.data;
          REG_MARGIN: eps = cfg.data;
          default: ;
        endcase
      end
      // compare each result transfer with the oldest owed point
      if (res.valid && res.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d kind=%0d",
                                    res.out_x, res.out_y, res.item_kind));
        end else begin
          want = expected_points.pop_front();
          checked++;
          if (res.item_kind == KIND_CROSS) crossings++;
          if (res.out_x !== want.x)
            report_mismatch($sformatf("out_x %0d, expected %0d", res.out_x, want.x));
          if (res.out_y !== want.y)
            report_mismatch($sformatf("out_y %0d, expected %0d", res.out_y, want.y));
          if (res.item_kind !== want.kind)
            report_mismatch($sformatf("item_kind %0d, expected %0d", res.item_kind, want.kind));
        end
      end
      // predict from each vertex transfer
      if (vtx.valid && vtx.ready) accept_vertex(vtx.vertex_x, vtx.vertex_y, vtx.final_vertex);
    end
    pending = expected_points.size();
  end

endmodule

### tb/halfplane_polygon_clipper_tb.sv
// Testbench top of the half-plane polygon clipper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module halfplane_polygon_clipper_tb;
  import hpc_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int SETTLE_CYCLES  = 3 * FRAC_BITS + 40;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_VERTICES = 50;

  localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] QMIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bit steady = 1'b0;
  int hold_request = 0;
  int hold_left = 0;

  int mismatches, points_pending, points_checked, crossings_seen;
  int vertices_sent = 0;
  int polygons_sent = 0;
  int settings_made = 0;

  hpc_vertex_if vtx ();
  hpc_result_if res ();
  hpc_cfg_if    cfg ();

  halfplane_polygon_clipper #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk (clk),
    .rst (rst),
    .vtx (vtx),
    .res (res),
    .cfg (cfg)
  );

  halfplane_clip_checker #(.FRAC_BITS(FRAC_BITS)) clip_check (
    .clk       (clk),
    .rst       (rst),
    .vtx       (vtx),
    .res       (res),
    .cfg       (cfg),
    .errors    (mismatches),
    .pending   (points_pending),
    .checked   (points_checked),
    .crossings (crossings_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, a long hold on request, none while steady
  always @(negedge clk) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      res.ready = 1'b0;
      hold_left--;
    end else begin
      res.ready = steady ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(input int wide_pct);
    int r;
    r = $urandom_range(99);
    if (r < wide_pct) return $urandom;
    if (r < wide_pct + 5) begin
      case ($urandom_range(4))
        0: return QMAX;
        1: return QMIN;
        2: return '0;
        3: return -1;
        default: return ONE;
      endcase
    end
    return rand_span(8 * ONE);
  endfunction

  // Offer one vertex, with random gaps, and hold it until the transfer
  task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, input logic last);
    if (!steady) begin
      while ($urandom_range(99) < 14) begin
        vtx.valid = 1'b0;
        @(negedge clk);
      end
    end
    vtx.valid = 1'b1;
    vtx.vertex_x = x;
    vtx.vertex_y = y;
    vtx.final_vertex = last;
    do @(posedge clk); while (!vtx.ready);
    @(negedge clk);
    vertices_sent++;
    if (last) polygons_sent++;
  endtask

  task automatic send_polygon(input int wide_pct);
    int r, n;
    r = $urandom_range(19);
    n = (r < 1) ? 1 : (r < 3) ? 2 : (r < 5) ? $urandom_range(8, 12) : $urandom_range(3, 6);
    for (int i = 0; i < n; i++)
      send_vertex(rand_coord(wide_pct), rand_coord(wide_pct), i == n - 1);
  endtask

  // Stop offering, wait for every owed result, then let the sequencer finish
  task automatic settle();
    vtx.valid = 1'b0;
    while (points_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [COORD_W-1:0] value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
  endtask

  task automatic set_line(input logic signed [COORD_W-1:0] a, b, c, m);
    settle();
    write_reg(REG_LINE_A, a);
    write_reg(REG_LINE_B, b);
    write_reg(REG_LINE_C, c);
    write_reg(REG_MARGIN, m);
    cfg.valid = 1'b0;
    settings_made++;
  endtask

  initial begin
    int phase_start;
    int wide_pct;
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.final_vertex = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_LINE_A;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset line: every side is zero, so everything is kept
    send_vertex(ONE, -ONE, 1'b0);
    send_vertex(-3 * ONE, 2 * ONE, 1'b1);

    // x >= 0: single vertex in and out, a clipped triangle, vertices on the line
    set_line(ONE, '0, '0, '0);
    send_vertex(2 * ONE, ONE, 1'b1);
    send_vertex(-ONE, '0, 1'b1);
    send_vertex(-ONE, '0, 1'b0);
    send_vertex(ONE, ONE, 1'b0);
    send_vertex(ONE, -ONE, 1'b1);
    send_vertex('0, 5 * ONE, 1'b0);
    send_vertex(-2 * ONE, '0, 1'b0);
    send_vertex('0, -5 * ONE, 1'b1);
    send_vertex(-ONE, ONE, 1'b0);
    send_vertex(-2 * ONE, -ONE, 1'b1);

    // change the line in the middle of a polygon
    send_vertex(-ONE, '0, 1'b0);
    send_vertex(ONE, '0, 1'b0);
    set_line(-ONE, '0, '0, '0);
    send_vertex(ONE, ONE, 1'b1);

    // saturated side values, both signs, and a crossing between them
    set_line(QMAX, QMAX, QMAX, QMIN);
    send_vertex(QMAX, QMAX, 1'b0);
    send_vertex(QMIN, QMIN, 1'b1);
    set_line(QMIN, QMIN, QMIN, QMAX);
    send_vertex(QMAX, QMAX, 1'b0);
    send_vertex(QMIN, QMIN, 1'b0);
    send_vertex(QMAX, QMIN, 1'b1);

    // margin pushes everything out, then exactly onto the line
    set_line('0, '0, ONE, 2 * ONE);
    send_vertex('0, '0, 1'b1);
    set_line('0, '0, ONE, ONE);
    send_vertex(QMIN, QMAX, 1'b1);

    // random polygons under several lines
    for (int phase = 0; phase < 6; phase++) begin
      wide_pct = (phase == 3 || phase == 4) ? 40 : 5;
      case (phase)
        3: set_line($urandom, $urandom, $urandom, $urandom);
        4: set_line($urandom_range(1) ? QMAX : QMIN, $urandom_range(1) ? QMAX : QMIN,
                    $urandom_range(1) ? QMAX : QMIN, $urandom_range(1) ? QMAX : '0);
        default: set_line(rand_span(2 * ONE), rand_span(2 * ONE), rand_span(4 * ONE),
                          rand_span(phase == 5 ? 4 * ONE : ONE / 2));
      endcase
      steady = (phase == 1);
      // hold the result side long enough to back up the vertex side
      if (phase == 2) hold_request = LONG_HOLD;
      phase_start = vertices_sent;
      while (vertices_sent - phase_start < PHASE_VERTICES) send_polygon(wide_pct);
    end

    settle();
    $display("covered %0d vertices in %0d polygons under %0d line settings",
             vertices_sent, polygons_sent, settings_made);
    $display("compared %0d results, %0d crossing points; %0d mismatches",
             points_checked, crossings_seen, mismatches);
    if (mismatches == 0 && points_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("timeout with %0d results still owed", points_pending);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### halfplane_polygon_clipper.f
+incdir+design
design/hpc_pkg.sv
design/hpc_if.sv
design/halfplane_polygon_clipper.sv
design/hpc_checker.sv
tb/halfplane_clip_checker.sv
tb/halfplane_polygon_clipper_tb.sv
